// ===== hw/rtl/lwbc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwbc_pkg
// Shared types, codes and helpers for the LRU write-back block cache.
// ----------------------------------------------------------------------------
package lwbc_pkg;

    localparam int unsigned DEF_CACHE_ENTRIES = 8;
    localparam int unsigned DEF_STORE_BLOCKS  = 128;
    localparam int unsigned DEF_WORD_BITS     = 32;

    // block number field width (fixed by the interface)
    localparam int unsigned BLK_W = 7;

    // access kinds
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // per-cycle control broadcast to every cell of the recency chain
    typedef struct packed {
        logic upd;   // commit the access this cycle
        logic miss;  // no cell matched: whole chain shifts, LRU drops out
    } t_cell_ctl;

    // block number modulo store size by reciprocal multiplication;
    // a 16-bit fraction is exact for 7-bit operands and divisors below 128,
    // larger stores never wrap a 7-bit block number
    function automatic logic [BLK_W-1:0] blk_wrap(input logic [BLK_W-1:0] v,
                                                  input int unsigned n);
        logic [31:0] m;
        logic [31:0] q;
        logic [31:0] r;
        if (n >= (32'd1 << BLK_W)) begin
            return v;
        end
        m = (32'd65536 + 32'(n) - 32'd1) / 32'(n);
        q = (32'(v) * m) >> 16;
        r = 32'(v) - q * 32'(n);
        return BLK_W'(r);
    endfunction

endpackage : lwbc_pkg
`default_nettype wire

// ===== hw/rtl/lwbc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwbc_cell
// One cache entry in the recency chain; loads from its upper neighbor.
// ----------------------------------------------------------------------------
module lwbc_cell #(
    parameter int unsigned WORD_BITS = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  lwbc_pkg::t_cell_ctl             i_ctl,
    input  wire  [lwbc_pkg::BLK_W-1:0]      i_tag_cmp,
    input  wire                             i_chain,
    output logic                            o_chain,
    output logic                            o_match,
    input  wire                             i_nxt_valid,
    input  wire                             i_nxt_dirty,
    input  wire  [lwbc_pkg::BLK_W-1:0]      i_nxt_tag,
    input  wire  [WORD_BITS-1:0]            i_nxt_word,
    output logic                            o_valid,
    output logic                            o_dirty,
    output logic [lwbc_pkg::BLK_W-1:0]      o_tag,
    output logic [WORD_BITS-1:0]            o_word
);
    import lwbc_pkg::*;

    logic                 r_valid;
    logic                 r_dirty;
    logic [BLK_W-1:0]     r_tag;
    logic [WORD_BITS-1:0] r_word;
    logic                 w_load;

    assign o_match = r_valid && (r_tag == i_tag_cmp);
    // set from the matching cell upward: those cells close the gap
    assign o_chain = i_chain | o_match;
    assign w_load  = i_ctl.upd & (i_ctl.miss | o_chain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_tag   <= '0;
        end else if (w_load) begin
            r_valid <= i_nxt_valid;
            r_dirty <= i_nxt_dirty;
            r_tag   <= i_nxt_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= i_nxt_word;
        end
    end

    assign o_valid = r_valid;
    assign o_dirty = r_dirty;
    assign o_tag   = r_tag;
    assign o_word  = r_word;

endmodule : lwbc_cell
`default_nettype wire

// ===== hw/rtl/lwbc_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwbc_store
// Backing store RAM with a post-reset init sweep (word i holds i).
// ----------------------------------------------------------------------------
module lwbc_store #(
    parameter int unsigned STORE_BLOCKS = 128,
    parameter int unsigned WORD_BITS    = 32,
    localparam int unsigned SB_AW       = $clog2(STORE_BLOCKS)
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    output logic                 o_busy,
    input  wire                  i_rd_en,
    input  wire  [SB_AW-1:0]     i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  wire                  i_wr_en,
    input  wire  [SB_AW-1:0]     i_wr_addr,
    input  wire  [WORD_BITS-1:0] i_wr_data
);
    logic [WORD_BITS-1:0] r_mem [STORE_BLOCKS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_busy;
    logic [SB_AW-1:0]     r_clr_addr;
    logic                 w_we;
    logic [SB_AW-1:0]     w_waddr;
    logic [WORD_BITS-1:0] w_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == SB_AW'(STORE_BLOCKS - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign w_we    = r_busy | i_wr_en;
    assign w_waddr = r_busy ? r_clr_addr : i_wr_addr;
    assign w_wdata = r_busy ? WORD_BITS'(r_clr_addr) : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_busy    = r_busy;
    assign o_rd_data = r_rd_data;

endmodule : lwbc_store
`default_nettype wire

// ===== hw/rtl/lru_write_back_block_cache.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_write_back_block_cache
// Fully associative LRU write-back cache over an internal backing store.
// ----------------------------------------------------------------------------
// Timing: the store read is issued at accept, then lookup and commit load
//   the result register; commit waits while the output register is full.
// Overlap: none; a new access is taken only after the last one commits,
//   since its store read must land before the cells and write-back commit.
// Reset: synchronous; cells clear at once, then the store init sweep runs
//   with s_axis_tready low.
// ----------------------------------------------------------------------------
module lru_write_back_block_cache #(
    parameter int unsigned CACHE_ENTRIES = lwbc_pkg::DEF_CACHE_ENTRIES,
    parameter int unsigned STORE_BLOCKS  = lwbc_pkg::DEF_STORE_BLOCKS,
    parameter int unsigned WORD_BITS     = lwbc_pkg::DEF_WORD_BITS,
    localparam int unsigned DATA_W       = WORD_BITS + lwbc_pkg::BLK_W,
    localparam int unsigned TDATA_W      = ((DATA_W + 7) / 8) * 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // slave side
    input  wire                s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire  [TDATA_W-1:0] s_axis_tdata,  // block_number, write_data, zero pad
    input  wire                s_axis_tuser,  // opcode
    // master side
    output logic               m_axis_tvalid,
    input  wire                m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // read_data, victim_block, zero pad
    output logic [1:0]         m_axis_tuser   // hit, wrote_back
);
    import lwbc_pkg::*;

    localparam int unsigned SB_AW = $clog2(STORE_BLOCKS);

    // two-phase sequencer: accept (issue store read), then commit
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 r_state;
    logic                 r_op;
    logic [BLK_W-1:0]     r_blk;
    logic [WORD_BITS-1:0] r_wdata;

    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_rdata;
    logic [BLK_W-1:0]     r_out_victim;
    logic                 r_out_hit;
    logic                 r_out_wb;

    logic                 w_in_fire;
    logic                 w_exec_fire;
    logic [BLK_W-1:0]     w_in_blk;
    logic                 w_clr_busy;
    logic [WORD_BITS-1:0] w_store_rd;

    // recency chain: cell 0 is least recent, last cell most recent
    logic [CACHE_ENTRIES-1:0] w_match;
    logic [CACHE_ENTRIES-1:0] w_chain;
    logic [CACHE_ENTRIES-1:0] w_valid;
    logic [CACHE_ENTRIES-1:0] w_dirty;
    logic [BLK_W-1:0]         w_tag  [CACHE_ENTRIES];
    logic [WORD_BITS-1:0]     w_word [CACHE_ENTRIES];
    t_cell_ctl                w_ctl;

    logic                 w_hit;
    logic                 w_hit_dirty;
    logic [WORD_BITS-1:0] w_hit_word;
    logic                 w_wb;
    logic [WORD_BITS-1:0] w_cur_word;
    logic [WORD_BITS-1:0] w_new_word;
    logic                 w_new_dirty;

    assign s_axis_tready = (r_state == ST_IDLE) && !w_clr_busy;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;
    // commit only when the output register is free or being drained
    assign w_exec_fire   = (r_state == ST_EXEC) && (!r_out_valid || m_axis_tready);
    assign w_in_blk      = blk_wrap(s_axis_tdata[BLK_W-1:0], STORE_BLOCKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_fire) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_exec_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_op    <= s_axis_tuser;
            r_blk   <= w_in_blk;
            r_wdata <= s_axis_tdata[BLK_W +: WORD_BITS];
        end
    end

    // backing store: read at accept, victim write-back at commit
    lwbc_store #(
        .STORE_BLOCKS (STORE_BLOCKS),
        .WORD_BITS    (WORD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .o_busy    (w_clr_busy),
        .i_rd_en   (w_in_fire),
        .i_rd_addr (SB_AW'(w_in_blk)),
        .o_rd_data (w_store_rd),
        .i_wr_en   (w_exec_fire && w_wb),
        .i_wr_addr (SB_AW'(w_tag[0])),
        .i_wr_data (w_word[0])
    );

    // hit lookup: tags among valid cells are unique, so an OR select is enough
    always_comb begin
        w_hit_word  = '0;
        w_hit_dirty = 1'b0;
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (w_match[i]) begin
                w_hit_word  = w_hit_word | w_word[i];
                w_hit_dirty = w_hit_dirty | w_dirty[i];
            end
        end
    end

    assign w_hit = |w_match;
    // miss evicts cell 0; never-used entries sit at the bottom of the chain
    assign w_wb  = !w_hit && w_valid[0] && w_dirty[0];

    assign w_cur_word  = w_hit ? w_hit_word : w_store_rd;
    assign w_new_word  = (r_op == OP_WRITE) ? r_wdata : w_cur_word;
    assign w_new_dirty = (r_op == OP_WRITE) || (w_hit && w_hit_dirty);

    assign w_ctl.upd  = w_exec_fire;
    assign w_ctl.miss = !w_hit;

    for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
        logic                 w_nv;
        logic                 w_nd;
        logic [BLK_W-1:0]     w_nt;
        logic [WORD_BITS-1:0] w_nw;
        logic                 w_cin;

        if (g == CACHE_ENTRIES - 1) begin : g_top
            // most recent slot takes the accessed entry
            assign w_nv = 1'b1;
            assign w_nd = w_new_dirty;
            assign w_nt = r_blk;
            assign w_nw = w_new_word;
        end else begin : g_mid
            assign w_nv = w_valid[g+1];
            assign w_nd = w_dirty[g+1];
            assign w_nt = w_tag[g+1];
            assign w_nw = w_word[g+1];
        end

        if (g == 0) begin : g_first
            assign w_cin = 1'b0;
        end else begin : g_rest
            assign w_cin = w_chain[g-1];
        end

        lwbc_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_tag_cmp   (r_blk),
            .i_chain     (w_cin),
            .o_chain     (w_chain[g]),
            .o_match     (w_match[g]),
            .i_nxt_valid (w_nv),
            .i_nxt_dirty (w_nd),
            .i_nxt_tag   (w_nt),
            .i_nxt_word  (w_nw),
            .o_valid     (w_valid[g]),
            .o_dirty     (w_dirty[g]),
            .o_tag       (w_tag[g]),
            .o_word      (w_word[g])
        );
    end

    // output register decouples the commit from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec_fire) begin
            r_out_rdata  <= (r_op == OP_WRITE) ? '0 : w_cur_word;
            r_out_hit    <= w_hit;
            r_out_wb     <= w_wb;
            r_out_victim <= w_wb ? w_tag[0] : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDATA_W'({r_out_victim, r_out_rdata});
    assign m_axis_tuser  = {r_out_wb, r_out_hit};

`ifndef SYNTHESIS
    // valid tags never repeat in the chain
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $onehot0(w_match))
        else $error("more than one cell matched the tag");

    // empty entries stay packed at the least recent end
    a_valid_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((CACHE_ENTRIES'(w_valid << 1) & ~w_valid) == '0))
        else $error("invalid entry above a valid one in the chain");

    // the accessed block ends up most recent
    a_mru_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec_fire |=> (w_valid[CACHE_ENTRIES-1] &&
                         (w_tag[CACHE_ENTRIES-1] == $past(r_blk))))
        else $error("accessed block not placed at most recent position");

    // every commit yields a result
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec_fire |=> r_out_valid)
        else $error("commit without result");
`endif

endmodule : lru_write_back_block_cache
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU write-back block cache. An access-level
// copy of the cache and backing store computes each read word, hit flag and
// write-back for every accepted access. Results are compared in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int unsigned N_ENTRIES  = 8;
    localparam int unsigned N_BLOCKS   = 128;
    localparam int unsigned TDATA_W    = 40;
    localparam int unsigned N_RANDOM   = 1125;
    localparam int unsigned CALM_TAIL  = 150;   // no idling for the last accesses
    localparam int unsigned IDLE_LIMIT = 3000;  // covers the store init sweep
    localparam int unsigned DRAIN_CYC  = 8;

    typedef struct packed {
        logic        op;
        logic [6:0]  blk;
        logic [31:0] wdata;
    } access_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        hit;
        logic        wb;
        logic [6:0]  victim;
    } access_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    wire                s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;  // block_number, write_data, zero pad
    logic               s_axis_tuser = lwbc_pkg::OP_READ;  // opcode
    wire                m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    wire  [TDATA_W-1:0] m_axis_tdata;       // read_data, victim_block, zero pad
    wire  [1:0]         m_axis_tuser;       // hit, wrote_back

    lru_write_back_block_cache DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // shadow cache state
    logic        line_valid [N_ENTRIES];
    logic [6:0]  line_tag   [N_ENTRIES];
    logic        line_dirty [N_ENTRIES];
    logic [31:0] line_word  [N_ENTRIES];
    logic [2:0]  lru_order  [N_ENTRIES];  // [0] least recent, last most recent
    logic [31:0] store_word [N_BLOCKS];

    access_t        access_queue[$];
    access_result_t lookup_results_q[$];
    access_t        on_bus;

    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatch_count = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned hit_count = 0;
    int unsigned wb_count = 0;
    int unsigned write_count = 0;
    bit          calm_tail = 1'b0;

    // One access against the shadow cache; updates state, returns the reply.
    function automatic access_result_t cache_access(input access_t a);
        access_result_t r;
        int unsigned    slot;
        int unsigned    pos;
        bit             found;
        logic [6:0]     blk;
        r     = '0;
        slot  = 0;
        pos   = 0;
        found = 1'b0;
        blk   = 7'(a.blk % N_BLOCKS);
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (!found && line_valid[i] && line_tag[i] == blk) begin
                found = 1'b1;
                slot  = i;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            if (a.op == lwbc_pkg::OP_WRITE) begin
                line_word[slot]  = a.wdata;
                line_dirty[slot] = 1'b1;
            end else begin
                r.rdata = line_word[slot];
            end
        end else begin
            slot = lru_order[0];
            if (line_valid[slot] && line_dirty[slot]) begin
                store_word[line_tag[slot]] = line_word[slot];
                r.wb     = 1'b1;
                r.victim = line_tag[slot];
            end
            line_valid[slot] = 1'b1;
            line_tag[slot]   = blk;
            if (a.op == lwbc_pkg::OP_WRITE) begin
                line_word[slot]  = a.wdata;
                line_dirty[slot] = 1'b1;
            end else begin
                line_word[slot]  = store_word[blk];
                line_dirty[slot] = 1'b0;
                r.rdata          = line_word[slot];
            end
        end
        // move the used entry to the most recent end
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (lru_order[i] == 3'(slot)) pos = i;
        end
        for (int i = pos; i + 1 < N_ENTRIES; i++) begin
            lru_order[i] = lru_order[i + 1];
        end
        lru_order[N_ENTRIES - 1] = 3'(slot);
        return r;
    endfunction

    task automatic push_access(input logic op, input logic [6:0] blk,
                               input logic [31:0] wdata);
        access_t a;
        a.op    = op;
        a.blk   = blk;
        a.wdata = wdata;
        access_queue.push_back(a);
    endtask

    // driver: loads the next access once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                lookup_results_q.push_back(cache_access(on_bus));
                n_accepted++;
                if (on_bus.op == lwbc_pkg::OP_WRITE) write_count++;
            end
            calm_tail = (access_queue.size() < CALM_TAIL);
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (access_queue.size() > 0) begin
                on_bus = access_queue.pop_front();
                s_axis_tdata  <= {1'b0, on_bus.wdata, on_bus.blk};
                s_axis_tuser  <= on_bus.op;
                s_axis_tvalid <= 1'b1;
                if (!calm_tail && $urandom_range(0, 99) < 10) begin
                    src_gap = $urandom_range(1, 9);
                end
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: checks each reply against the oldest computed one
    always @(posedge i_clk) begin
        access_result_t got;
        access_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.rdata  = m_axis_tdata[31:0];
                got.victim = m_axis_tdata[38:32];
                got.hit    = m_axis_tuser[0];
                got.wb     = m_axis_tuser[1];
                n_results++;
                if (got.hit) hit_count++;
                if (got.wb) wb_count++;
                if (lookup_results_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("unexpected reply: data %h hit %b wb %b victim %0d",
                                 got.rdata, got.hit, got.wb, got.victim);
                    end
                end else begin
                    want = lookup_results_q.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("reply %0d: exp data %h hit %b wb %b victim %0d",
                                     n_results, want.rdata, want.hit, want.wb,
                                     want.victim);
                            $display("reply %0d: got data %h hit %b wb %b victim %0d",
                                     n_results, got.rdata, got.hit, got.wb,
                                     got.victim);
                        end
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!calm_tail && $urandom_range(0, 99) < 10) begin
                    sink_gap = $urandom_range(1, 9);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d cycles without a transfer", idle_cycles);
                $display("lru_write_back_block_cache: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int unsigned base;
        int unsigned span;
        logic [6:0]  blk;
        for (int i = 0; i < N_ENTRIES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_dirty[i] = 1'b0;
            line_word[i]  = '0;
            lru_order[i]  = 3'(i);
        end
        for (int i = 0; i < N_BLOCKS; i++) store_word[i] = 32'(i);

        // directed: extremes, fill, dirty and clean evictions, write-back readback
        push_access(lwbc_pkg::OP_READ,  7'd0,   32'hFFFF_FFFF);
        push_access(lwbc_pkg::OP_READ,  7'd127, 32'h0);
        push_access(lwbc_pkg::OP_WRITE, 7'd127, 32'hFFFF_FFFF);
        push_access(lwbc_pkg::OP_WRITE, 7'd0,   32'h0000_0000);
        push_access(lwbc_pkg::OP_WRITE, 7'd5,   32'hA5A5_A5A5);
        for (int b = 10; b < 15; b++) push_access(lwbc_pkg::OP_READ, 7'(b), 32'h0);
        push_access(lwbc_pkg::OP_READ,  7'd20,  32'h0);
        push_access(lwbc_pkg::OP_READ,  7'd127, 32'h0);
        push_access(lwbc_pkg::OP_READ,  7'd0,   32'h0);
        push_access(lwbc_pkg::OP_WRITE, 7'd64,  32'h5A5A_5A5A);
        push_access(lwbc_pkg::OP_READ,  7'd5,   32'h0);
        push_access(lwbc_pkg::OP_READ,  7'd20,  32'h1234_5678);
        push_access(lwbc_pkg::OP_WRITE, 7'd13,  32'h8000_0001);
        push_access(lwbc_pkg::OP_READ,  7'd13,  32'h0);
        push_access(lwbc_pkg::OP_WRITE, 7'd64,  32'h7FFF_FFFE);
        for (int b = 30; b < 37; b++) push_access(lwbc_pkg::OP_READ, 7'(b), 32'h0);
        push_access(lwbc_pkg::OP_READ,  7'd64,  32'h0);

        // random: mostly a drifting working set a bit larger than the cache
        base = $urandom_range(0, 127);
        span = 11;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) begin
                base = $urandom_range(0, 127);
                span = $urandom_range(8, 16);
            end
            if ($urandom_range(0, 99) < 75) blk = 7'((base + $urandom_range(0, span - 1)) % N_BLOCKS);
            else blk = 7'($urandom_range(0, 127));
            push_access(logic'($urandom_range(0, 1)), blk, $urandom);
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (access_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (lookup_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (lookup_results_q.size() != 0) mismatch_count++;
        $display("%0d accesses (%0d writes), %0d replies checked", n_accepted,
                 write_count, n_results);
        $display("%0d hits, %0d dirty write-backs", hit_count, wb_count);
        if (mismatch_count == 0) begin
            $display("lru_write_back_block_cache: match");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("lru_write_back_block_cache: mismatch");
        end
        $finish;
    end

endmodule
